>>> rtl/core/cksum_pkg.sv
// shared types, constants and the crc byte update function for the cksum engine
`default_nettype none

package cksum_pkg;

  localparam int unsigned LengthWidthDef = 64;
  localparam int unsigned CfgIdxWidth    = 2;
  localparam int unsigned CfgDataWidth   = 1;

  localparam logic [31:0] PolyMsb  = 32'h04C1_1DB7;
  localparam logic [31:0] PolyLsb  = 32'hEDB8_8320;
  localparam logic [31:0] AllOnes  = 32'hFFFF_FFFF;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgReflected = 2'd0,
    CfgPreInvert = 2'd1,
    CfgSkipPost  = 2'd2,
    CfgSkipLen   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ActData = 1'b0,
    ActEof  = 1'b1
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [31:0] crc_result;
    logic [63:0] byte_length;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic byte_en;
    logic eof_load;
    logic fold_en;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rest_zero;
  } dp_status_t;

  // one byte through the crc, bit by bit
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b,
                                           input logic        refl);
    logic [31:0] c;
    c = crc_in;
    if (refl) begin
      c = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ PolyLsb) : (c >> 1);
      end
    end else begin
      c = c ^ {b, 24'd0};
      for (int i = 0; i < 8; i++) begin
        c = c[31] ? ((c << 1) ^ PolyMsb) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cksum_crc32_engine_unit.sv
// top level of the cksum style crc-32 engine
// usage:
//   input channel (in_valid_i / in_ready_o handshake on in_req_i) carries
//   one request per item: a data byte or an end-of-file marker.
//   data byte requests stream at one per cycle while the engine is idle.
//   after an end-of-file request no new request is taken until its result is
//   written; the fold passes n (0..LENGTH_WIDTH/8) count bytes, one per cycle,
//   through the single crc byte update unit.
//   the result (crc and byte length) is registered into the output register
//   when the fold ends and stays until out_ready_i is seen with out_valid_o.
//   while a result waits, data bytes keep being taken; a second end of file
//   holds in the fold state until the output register is free.
//   configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i),
//   to be written only while the engine is idle; the block does not enforce it.
//   reset clears all config bits, the crc to zero, the count to zero and the
//   output valid flag.
`default_nettype none

module cksum_crc32_engine_unit #(
  parameter int unsigned LENGTH_WIDTH = cksum_pkg::LengthWidthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cksum_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [cksum_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire cksum_pkg::in_req_t                 in_req_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output cksum_pkg::out_rsp_t                     out_rsp_o
);

  cksum_pkg::dp_cmd_t    cmd;
  cksum_pkg::dp_status_t status;

  cksum_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_req_i.action),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cksum_dp #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .data_byte_i (in_req_i.data_byte),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/cksum_ctrl.sv
// controller: request handshakes, length fold sequencing, result valid
`default_nettype none

module cksum_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire cksum_pkg::action_e     in_action_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire cksum_pkg::dp_status_t  status_i,
  output cksum_pkg::dp_cmd_t          cmd_o
);

  typedef enum logic {
    StIdle,
    StFold
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  // result slot is free if empty or being taken this cycle
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.byte_en  = accept && (in_action_i == cksum_pkg::ActData);
    cmd_o.eof_load = accept && (in_action_i == cksum_pkg::ActEof);
    cmd_o.fold_en  = (state_q == StFold) && !status_i.rest_zero;
    cmd_o.finish   = (state_q == StFold) && status_i.rest_zero && out_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (cmd_o.eof_load) begin
          state_d = StFold;
        end
      end
      StFold: begin
        if (cmd_o.finish) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/cksum_dp.sv
// datapath: config registers, crc and byte count, fold shifter, result register
`default_nettype none

module cksum_dp #(
  parameter int unsigned LENGTH_WIDTH = cksum_pkg::LengthWidthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cksum_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [cksum_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  input  wire logic [7:0]                         data_byte_i,
  input  wire cksum_pkg::dp_cmd_t                 cmd_i,
  output cksum_pkg::dp_status_t                   status_o,
  output cksum_pkg::out_rsp_t                     out_rsp_o
);

  logic refl_q, refl_d;
  logic pre_inv_q, pre_inv_d;
  logic skip_post_q, skip_post_d;
  logic skip_len_q, skip_len_d;

  logic [31:0]             crc_q, crc_d;
  logic [LENGTH_WIDTH-1:0] count_q, count_d;
  logic [LENGTH_WIDTH-1:0] rest_q, rest_d;
  cksum_pkg::out_rsp_t     out_q, out_d;

  logic [31:0] start_val;
  logic [31:0] crc_upd;
  logic [7:0]  upd_byte;

  assign start_val = pre_inv_q ? cksum_pkg::AllOnes : 32'd0;
  assign upd_byte  = cmd_i.fold_en ? rest_q[7:0] : data_byte_i;
  assign crc_upd   = cksum_pkg::crc_byte(crc_q, upd_byte, refl_q);

  always_comb begin
    refl_d      = refl_q;
    pre_inv_d   = pre_inv_q;
    skip_post_d = skip_post_q;
    skip_len_d  = skip_len_q;
    crc_d       = crc_q;
    count_d     = count_q;
    rest_d      = rest_q;
    out_d       = out_q;

    if (cfg_we_i) begin
      unique case (cksum_pkg::cfg_idx_e'(cfg_index_i))
        cksum_pkg::CfgReflected: refl_d = cfg_wdata_i[0];
        cksum_pkg::CfgPreInvert: begin
          pre_inv_d = cfg_wdata_i[0];
          // fresh file: reload the start value right away
          if (count_q == '0) begin
            crc_d = {32{cfg_wdata_i[0]}};
          end
        end
        cksum_pkg::CfgSkipPost:  skip_post_d = cfg_wdata_i[0];
        cksum_pkg::CfgSkipLen:   skip_len_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end

    if (cmd_i.byte_en) begin
      crc_d   = crc_upd;
      count_d = count_q + LENGTH_WIDTH'(1);
    end

    if (cmd_i.eof_load) begin
      rest_d = skip_len_q ? '0 : count_q;
    end

    // fold the count low byte first until the remaining high part is zero
    if (cmd_i.fold_en) begin
      crc_d  = crc_upd;
      rest_d = rest_q >> 8;
    end

    if (cmd_i.finish) begin
      out_d.crc_result  = crc_q ^ {32{~skip_post_q}};
      out_d.byte_length = 64'(count_q);
      crc_d             = start_val;
      count_d           = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refl_q      <= 1'b0;
      pre_inv_q   <= 1'b0;
      skip_post_q <= 1'b0;
      skip_len_q  <= 1'b0;
      crc_q       <= 32'd0;
      count_q     <= '0;
    end else begin
      refl_q      <= refl_d;
      pre_inv_q   <= pre_inv_d;
      skip_post_q <= skip_post_d;
      skip_len_q  <= skip_len_d;
      crc_q       <= crc_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    out_q  <= out_d;
  end

  assign status_o.rest_zero = (rest_q == '0);
  assign out_rsp_o          = out_q;

endmodule

`default_nettype wire
